// ----- rtl/wad_pkg.sv -----
// shared types and constants of the wear activity detector
`default_nettype none
package wad_pkg;

  localparam int ONE_G       = 4096;
  localparam int RUN_MAX     = 255;
  localparam int TIME_W      = 32;
  localparam int ACCEL_W     = 16;
  localparam int INTERVAL_W  = 16;
  localparam int THR_W       = 15;
  localparam int CONFIRM_W   = 8;
  localparam int RUN_W       = 8;
  localparam int HI_W        = 16;
  localparam int LO_W        = 13;
  localparam int HI_SQ_W     = 32;
  localparam int LO_SQ_W     = 26;
  localparam int SUM_W       = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_DATA_W   = 80;
  localparam int OUT_DATA_W  = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_INTERVAL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MOTION_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MOVING_CONFIRM   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STILL_CONFIRM    = 2'd3;

  // reset values
  localparam int INTERVAL_RESET = 100;
  localparam int THR_RESET      = 410;
  localparam int MOVING_RESET   = 3;
  localparam int STILL_RESET    = 50;
  localparam int HI_SQ_RESET    = (ONE_G + THR_RESET) * (ONE_G + THR_RESET);
  localparam int LO_SQ_RESET    = (ONE_G - THR_RESET) * (ONE_G - THR_RESET);

  typedef struct packed {
    logic [INTERVAL_W-1:0] sample_interval;
    logic [CONFIRM_W-1:0]  moving_confirm;
    logic [CONFIRM_W-1:0]  still_confirm;
    logic [HI_SQ_W-1:0]    hi_sq;
    logic [LO_SQ_W-1:0]    lo_sq;
    logic                  lo_en;
  } cfg_t;

  typedef struct packed {
    logic idle;
    logic sampled;
    logic above_threshold;
  } result_t;

endpackage
`default_nettype wire

// ----- rtl/wad_config.sv -----
// configuration registers and precomputed squared magnitude bounds
`default_nettype none
module wad_config (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [wad_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [wad_pkg::CFG_DATA_W-1:0] cfg_data,
  output wad_pkg::cfg_t                       cfg
);

  logic [wad_pkg::THR_W-1:0] motion_threshold;
  logic [wad_pkg::HI_W-1:0]  hi;
  logic [wad_pkg::LO_W-1:0]  lo;
  logic                      lo_en;

  always_comb begin
    hi    = wad_pkg::HI_W'(wad_pkg::ONE_G) + wad_pkg::HI_W'(motion_threshold);
    lo_en = motion_threshold < wad_pkg::THR_W'(wad_pkg::ONE_G);
    lo    = wad_pkg::LO_W'(wad_pkg::ONE_G) - motion_threshold[wad_pkg::LO_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sample_interval <= wad_pkg::INTERVAL_W'(wad_pkg::INTERVAL_RESET);
      motion_threshold    <= wad_pkg::THR_W'(wad_pkg::THR_RESET);
      cfg.moving_confirm  <= wad_pkg::CONFIRM_W'(wad_pkg::MOVING_RESET);
      cfg.still_confirm   <= wad_pkg::CONFIRM_W'(wad_pkg::STILL_RESET);
      cfg.hi_sq           <= wad_pkg::HI_SQ_W'(wad_pkg::HI_SQ_RESET);
      cfg.lo_sq           <= wad_pkg::LO_SQ_W'(wad_pkg::LO_SQ_RESET);
      cfg.lo_en           <= 1'b1;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          wad_pkg::REG_SAMPLE_INTERVAL:  cfg.sample_interval <= cfg_data;
          wad_pkg::REG_MOTION_THRESHOLD: motion_threshold <= cfg_data[wad_pkg::THR_W-1:0];
          wad_pkg::REG_MOVING_CONFIRM:   cfg.moving_confirm <= cfg_data[wad_pkg::CONFIRM_W-1:0];
          wad_pkg::REG_STILL_CONFIRM:    cfg.still_confirm <= cfg_data[wad_pkg::CONFIRM_W-1:0];
          default: ;
        endcase
      end
      // bounds are registered from the threshold register, so they follow it in the next cycle
      cfg.hi_sq <= wad_pkg::HI_SQ_W'(hi) * wad_pkg::HI_SQ_W'(hi);
      cfg.lo_sq <= wad_pkg::LO_SQ_W'(lo) * wad_pkg::LO_SQ_W'(lo);
      cfg.lo_en <= lo_en;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/wad_motion.sv -----
// magnitude test: sum of squares against the squared bounds
`default_nettype none
module wad_motion (
  input  wire logic                               read_ok,
  input  wire logic signed [wad_pkg::ACCEL_W-1:0] accel_x,
  input  wire logic signed [wad_pkg::ACCEL_W-1:0] accel_y,
  input  wire logic signed [wad_pkg::ACCEL_W-1:0] accel_z,
  input  wire wad_pkg::cfg_t                      cfg,
  output logic                                    moving
);

  logic signed [2*wad_pkg::ACCEL_W-1:0] sq_x, sq_y, sq_z;
  logic [wad_pkg::SUM_W-1:0]            sum;

  always_comb begin
    sq_x = accel_x * accel_x;
    sq_y = accel_y * accel_y;
    sq_z = accel_z * accel_z;
    // each square is at most 2^30, so the sum fits 32 bits
    sum  = wad_pkg::SUM_W'(sq_x) + wad_pkg::SUM_W'(sq_y) + wad_pkg::SUM_W'(sq_z);
    moving = read_ok &&
             ((sum > cfg.hi_sq) ||
              (cfg.lo_en && (sum < wad_pkg::SUM_W'(cfg.lo_sq))));
  end

endmodule
`default_nettype wire

// ----- rtl/wad_tracker.sv -----
// sample gating, run counters and the debounced wear state
`default_nettype none
module wad_tracker (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        advance,
  input  wire logic [wad_pkg::TIME_W-1:0]  now_ms,
  input  wire logic                        moving,
  input  wire wad_pkg::cfg_t               cfg,
  output wad_pkg::result_t                 result
);

  logic [wad_pkg::TIME_W-1:0] last_sample_time;
  logic [wad_pkg::RUN_W-1:0]  moving_run, moving_run_next;
  logic [wad_pkg::RUN_W-1:0]  still_run, still_run_next;
  logic                       idle_flag, idle_flag_next;
  logic [wad_pkg::TIME_W-1:0] elapsed;
  logic                       take;

  always_comb begin
    elapsed = now_ms - last_sample_time;
    take    = elapsed >= wad_pkg::TIME_W'(cfg.sample_interval);

    if (moving) begin
      moving_run_next = (moving_run == wad_pkg::RUN_W'(wad_pkg::RUN_MAX)) ?
                        moving_run : moving_run + wad_pkg::RUN_W'(1);
      still_run_next  = '0;
    end else begin
      still_run_next  = (still_run == wad_pkg::RUN_W'(wad_pkg::RUN_MAX)) ?
                        still_run : still_run + wad_pkg::RUN_W'(1);
      moving_run_next = '0;
    end

    if (!idle_flag) begin
      idle_flag_next = still_run_next >= cfg.still_confirm;
    end else begin
      idle_flag_next = !(moving_run_next >= cfg.moving_confirm);
    end

    result.idle            = take ? idle_flag_next : idle_flag;
    result.sampled         = take;
    result.above_threshold = take && moving;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_sample_time <= '0;
      moving_run       <= '0;
      still_run        <= '0;
      idle_flag        <= 1'b0;
    end else if (advance && take) begin
      last_sample_time <= now_ms;
      moving_run       <= moving_run_next;
      still_run        <= still_run_next;
      idle_flag        <= idle_flag_next;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/accel_wear_activity_detector.sv -----
// top level of the accelerometer wear activity detector
// an accepted item waits in the input register, then moves to the result register when that frees
// throughput: one item per cycle unless m_tready stalls; single compute stage between the registers
// rst (synchronous, active high) empties both registers, zeroes time and run state,
// marks the wearer active and loads the configuration reset values
`default_nettype none
module accel_wear_activity_detector (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // configuration write port
  input  wire logic                            cfg_we,
  input  wire logic [wad_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [wad_pkg::CFG_DATA_W-1:0]  cfg_data,
  // input items
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [wad_pkg::IN_DATA_W-1:0]   s_tdata,  // now_ms, accel_x, accel_y, accel_z
  input  wire logic                            s_tuser,  // read_ok
  // result items
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [wad_pkg::OUT_DATA_W-1:0]       m_tdata   // idle, sampled, above_threshold, zero pad
);

  wad_pkg::cfg_t    cfg;
  wad_pkg::result_t result;

  // input register
  logic                                in_valid;
  logic [wad_pkg::TIME_W-1:0]          in_now_ms;
  logic                                in_read_ok;
  logic signed [wad_pkg::ACCEL_W-1:0]  in_accel_x, in_accel_y, in_accel_z;

  // result register
  logic                                out_valid;
  wad_pkg::result_t                    out_result;

  logic load_out;
  logic advance;
  logic moving;

  // the result register frees when empty or being taken; the input register
  // then moves on in the same cycle, so ready does not wait for an empty block
  assign load_out = !out_valid || m_tready;
  assign advance  = in_valid && load_out;
  assign s_tready = !in_valid || load_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_now_ms  <= s_tdata[31:0];
      in_accel_x <= s_tdata[47:32];
      in_accel_y <= s_tdata[63:48];
      in_accel_z <= s_tdata[79:64];
      in_read_ok <= s_tuser;
    end
  end

  wad_config u_config (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // magnitude test against 1 g plus or minus the threshold, no square root
  wad_motion u_motion (
    .read_ok (in_read_ok),
    .accel_x (in_accel_x),
    .accel_y (in_accel_y),
    .accel_z (in_accel_z),
    .cfg     (cfg),
    .moving  (moving)
  );

  // state only commits when the item leaves the input register
  wad_tracker u_tracker (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .now_ms  (in_now_ms),
    .moving  (moving),
    .cfg     (cfg),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'b0, out_result.above_threshold, out_result.sampled, out_result.idle};

endmodule
`default_nettype wire

// ----- sim/wad_checker.sv -----
// result predictor and stream checker for the wear activity detector
module wad_checker
  import wad_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,  // now_ms, accel_x, accel_y, accel_z
  input  logic                  s_tuser,  // read_ok
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [OUT_DATA_W-1:0] m_tdata,  // idle, sampled, above_threshold, zero pad
  output int                    fail_count,
  output int                    outstanding
);

  logic [INTERVAL_W-1:0] interval_q;
  logic [THR_W-1:0]      thr_q;
  logic [CONFIRM_W-1:0]  go_active_q;
  logic [CONFIRM_W-1:0]  go_idle_q;
  logic [TIME_W-1:0]     last_time_q;
  logic [RUN_W-1:0]      moving_run_q;
  logic [RUN_W-1:0]      still_run_q;
  logic                  idle_q;

  result_t expected_status[$];
  int      fails = 0;

  // exact band test on the squared magnitude
  function automatic logic outside_band(logic signed [ACCEL_W-1:0] x, logic signed [ACCEL_W-1:0] y,
                                        logic signed [ACCEL_W-1:0] z, logic [THR_W-1:0] thr);
    longint sx, sy, sz, energy, hi, lo;
    sx = x;
    sy = y;
    sz = z;
    energy = sx * sx + sy * sy + sz * sz;
    hi = longint'(ONE_G) + longint'(thr);
    lo = longint'(ONE_G) - longint'(thr);
    if (energy > hi * hi) return 1'b1;
    if (longint'(thr) < longint'(ONE_G) && energy < lo * lo) return 1'b1;
    return 1'b0;
  endfunction

  function automatic result_t advance_detector(logic [TIME_W-1:0] now, logic ok,
                                               logic signed [ACCEL_W-1:0] x,
                                               logic signed [ACCEL_W-1:0] y,
                                               logic signed [ACCEL_W-1:0] z);
    result_t          r;
    logic [TIME_W-1:0] elapsed;
    logic             moving;
    elapsed = now - last_time_q;
    r.idle = idle_q;
    r.sampled = 1'b0;
    r.above_threshold = 1'b0;
    if (elapsed < TIME_W'(interval_q)) return r;
    last_time_q = now;
    moving = ok && outside_band(x, y, z, thr_q);
    if (moving) begin
      if (moving_run_q != RUN_W'(RUN_MAX)) moving_run_q = moving_run_q + RUN_W'(1);
      still_run_q = '0;
    end else begin
      if (still_run_q != RUN_W'(RUN_MAX)) still_run_q = still_run_q + RUN_W'(1);
      moving_run_q = '0;
    end
    if (!idle_q) begin
      if (still_run_q >= go_idle_q) idle_q = 1'b1;
    end else if (moving_run_q >= go_active_q) begin
      idle_q = 1'b0;
    end
    r.idle = idle_q;
    r.sampled = 1'b1;
    r.above_threshold = moving;
    return r;
  endfunction

  always @(posedge clk) begin
    result_t seen;
    result_t want;
    if (rst) begin
      interval_q   = INTERVAL_W'(INTERVAL_RESET);
      thr_q        = THR_W'(THR_RESET);
      go_active_q  = CONFIRM_W'(MOVING_RESET);
      go_idle_q    = CONFIRM_W'(STILL_RESET);
      last_time_q  = '0;
      moving_run_q = '0;
      still_run_q  = '0;
      idle_q       = 1'b0;
      expected_status.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        seen.idle            = m_tdata[0];
        seen.sampled         = m_tdata[1];
        seen.above_threshold = m_tdata[2];
        if (expected_status.size() == 0) begin
          $display("%0t unexpected result: idle %0b sampled %0b above %0b", $time,
                   seen.idle, seen.sampled, seen.above_threshold);
          fails++;
        end else begin
          want = expected_status.pop_front();
          if (seen.idle !== want.idle) begin
            $display("%0t idle: expected %0b got %0b", $time, want.idle, seen.idle);
            fails++;
          end
          if (seen.sampled !== want.sampled) begin
            $display("%0t sampled: expected %0b got %0b", $time, want.sampled, seen.sampled);
            fails++;
          end
          if (seen.above_threshold !== want.above_threshold) begin
            $display("%0t above_threshold: expected %0b got %0b", $time,
                     want.above_threshold, seen.above_threshold);
            fails++;
          end
        end
      end
      if (s_tvalid && s_tready)
        expected_status.push_back(advance_detector(s_tdata[TIME_W-1:0], s_tuser,
                                                   s_tdata[TIME_W +: ACCEL_W],
                                                   s_tdata[TIME_W+ACCEL_W +: ACCEL_W],
                                                   s_tdata[TIME_W+2*ACCEL_W +: ACCEL_W]));
      if (cfg_we) begin
        case (cfg_index)
          REG_SAMPLE_INTERVAL:  interval_q  = cfg_data[INTERVAL_W-1:0];
          REG_MOTION_THRESHOLD: thr_q       = cfg_data[THR_W-1:0];
          REG_MOVING_CONFIRM:   go_active_q = cfg_data[CONFIRM_W-1:0];
          REG_STILL_CONFIRM:    go_idle_q   = cfg_data[CONFIRM_W-1:0];
          default: ;
        endcase
      end
    end
    fail_count  <= fails;
    outstanding <= expected_status.size();
  end

endmodule

// ----- sim/tb_top.sv -----
// stimulus and verdict for the accelerometer wear activity detector
module tb_top;
  import wad_pkg::*;

  // generous bound: even the slowest legal run stays far below this
  localparam int CYCLE_LIMIT = 200000;

  typedef enum int {K_STILL, K_MOVING, K_BORDER, K_NOISE} burst_kind_e;

  typedef struct {
    logic [TIME_W-1:0]         now;
    logic                      ok;
    logic signed [ACCEL_W-1:0] x;
    logic signed [ACCEL_W-1:0] y;
    logic signed [ACCEL_W-1:0] z;
  } sample_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;  // now_ms, accel_x, accel_y, accel_z
  logic                  s_tuser = 1'b0;  // read_ok
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;  // idle, sampled, above_threshold, zero pad

  int fail_count;
  int outstanding;
  int cycle_count = 0;

  // when set, neither side inserts idle cycles
  logic calm = 1'b0;

  // shadow of the settings the stimulus is shaped around
  int                cur_interval = INTERVAL_RESET;
  int                cur_thr = THR_RESET;
  logic [TIME_W-1:0] clock_ms = '0;

  accel_wear_activity_detector dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  wad_checker chk (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always #6 clk = ~clk;

  // watchdog against a hung handshake
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // result side: random back-pressure before each result item
  initial begin
    int unsigned gap;
    forever begin
      gap = calm ? 0 : $urandom_range(0, 4);
      if (gap != 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  function automatic logic signed [ACCEL_W-1:0] clamp16(int v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  // one axis large enough that three of them clear even the widest band
  function automatic int big_axis();
    int v;
    v = int'($urandom_range(22000, 32767));
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  // accelerations for one item of a burst; the time is filled in by the caller
  function automatic sample_t draw_accel(burst_kind_e kind);
    sample_t r;
    int      hi;
    int      lo;
    int      m;
    hi = ONE_G + cur_thr;
    lo = ONE_G - cur_thr;
    r.now = '0;
    r.ok = 1'b1;
    r.x = clamp16(int'($urandom_range(0, 16)) - 8);
    r.y = clamp16(int'($urandom_range(0, 16)) - 8);
    m = ONE_G;
    case (kind)
      K_STILL: begin
        m = ONE_G + int'($urandom_range(0, 2 * cur_thr)) - cur_thr;
        // failed reads count as still whatever the axes say
        if ($urandom_range(0, 9) == 0) begin
          r.ok = 1'b0;
          r.x = 16'($urandom);
          r.y = 16'($urandom);
          m = int'($urandom_range(0, 65535)) - 32768;
        end
      end
      K_MOVING: begin
        if (hi > 32000) begin
          r.x = clamp16(big_axis());
          r.y = clamp16(big_axis());
          m = big_axis();
        end else if (lo > 16 && $urandom_range(0, 1)) begin
          m = int'($urandom_range(0, lo - 8));
        end else begin
          m = hi + 1 + int'($urandom_range(0, 32767 - hi - 1));
        end
      end
      K_BORDER: begin
        // single axis near a band edge, so the squares land on or just beside the bounds
        r.x = '0;
        r.y = '0;
        m = (lo >= 0 && $urandom_range(0, 1)) ? lo : hi;
        m = m + int'($urandom_range(0, 4)) - 2;
      end
      default: begin
        r.ok = 1'($urandom);
        r.x = 16'($urandom);
        r.y = 16'($urandom);
        m = int'($urandom_range(0, 65535)) - 32768;
      end
    endcase
    if ($urandom_range(0, 1)) m = -m;
    r.z = clamp16(m);
    return r;
  endfunction

  // time advance between items: mostly just past the interval, some too early
  function automatic logic [TIME_W-1:0] next_step(bit wild);
    if (wild) begin
      case ($urandom_range(0, 3))
        0: return $urandom;
        1: return $urandom_range(0, 3);
        2: return cur_interval;
        default: return $urandom_range(0, 2 * cur_interval + 1);
      endcase
    end
    if (cur_interval != 0 && $urandom_range(0, 7) == 0)
      return $urandom_range(0, cur_interval - 1);
    return cur_interval + $urandom_range(0, 3);
  endfunction

  task automatic send_sample(sample_t smp);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tdata  <= {smp.z, smp.y, smp.x, smp.now};
    s_tuser  <= smp.ok;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic poke(logic [TIME_W-1:0] now, logic ok, int x, int y, int z);
    sample_t smp;
    smp.now = now;
    smp.ok = ok;
    smp.x = clamp16(x);
    smp.y = clamp16(y);
    smp.z = clamp16(z);
    send_sample(smp);
  endtask

  // drain every outstanding result, then allow for the two-stage pipeline
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // unused upper bits of the write data are random: the block must mask them
  task automatic set_config(int interval, int thr, int mconf, int sconf);
    write_reg(REG_SAMPLE_INTERVAL, 16'(interval));
    write_reg(REG_MOTION_THRESHOLD, {1'($urandom), 15'(thr)});
    write_reg(REG_MOVING_CONFIRM, {8'($urandom), 8'(mconf)});
    write_reg(REG_STILL_CONFIRM, {8'($urandom), 8'(sconf)});
    cur_interval = interval;
    cur_thr = thr;
  endtask

  // bursts of like items so the debounce runs build up; long_runs opens with
  // a full still run and a full moving run to cross the widest confirm counts
  task automatic run_phase(int interval, int thr, int mconf, int sconf, int n_items,
                           int max_burst, logic [TIME_W-1:0] base, bit long_runs);
    int          sent;
    int          burst;
    int          len;
    int          k;
    int          pick;
    burst_kind_e kind;
    sample_t     smp;
    settle();
    set_config(interval, thr, mconf, sconf);
    clock_ms = base;
    sent = 0;
    burst = 0;
    while (sent < n_items) begin
      if (long_runs && burst < 2) begin
        kind = (burst == 0) ? K_STILL : K_MOVING;
        len = max_burst;
      end else begin
        pick = $urandom_range(0, 19);
        if (pick < 8) kind = K_STILL;
        else if (pick < 15) kind = K_MOVING;
        else if (pick < 17) kind = K_BORDER;
        else kind = K_NOISE;
        len = $urandom_range(1, max_burst);
      end
      calm <= ($urandom_range(0, 3) == 0);
      for (k = 0; k < len && sent < n_items; k++) begin
        smp = draw_accel(kind);
        clock_ms = clock_ms + next_step(kind == K_NOISE);
        smp.now = clock_ms;
        send_sample(smp);
        sent++;
      end
      burst++;
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: interval 100, band 410 around 1 g
    poke(0, 1'b1, 0, 0, 4096);                      // no time elapsed since reset
    poke(99, 1'b1, 0, 0, 4096);                     // one short of the interval
    poke(100, 1'b1, -32768, -32768, -32768);        // largest magnitude
    poke(200, 1'b1, 32767, 32767, 32767);
    poke(300, 1'b0, -32768, 32767, -32768);         // failed read counts as still
    poke(400, 1'b1, 0, 0, 4506);                    // exactly on the upper bound
    poke(500, 1'b1, 0, 0, -4507);                   // just past the upper bound
    poke(600, 1'b1, 0, 3686, 0);                    // exactly on the lower bound
    poke(700, 1'b1, 3685, 0, 0);                    // just under the lower bound
    poke(800, 1'b1, 0, 0, 0);                       // free fall
    poke(900, 1'b1, 0, 0, 0);

    // zero interval, zero confirm counts, threshold wide enough to drop the lower bound
    settle();
    set_config(0, 4096, 0, 0);
    poke(5, 1'b1, 0, 0, 0);
    poke(5, 1'b1, 0, 0, 0);                         // same timestamp still evaluated
    poke(5, 1'b1, 0, 0, 8193);
    poke(5, 1'b1, 0, 0, 8192);

    // widest settings and a timestamp wrap
    settle();
    set_config(65535, 32767, 255, 255);
    poke(32'hFFFF_FFF0, 1'b1, -32768, -32768, -32768);
    poke(32'h0000_FFEE, 1'b1, 0, 0, 0);             // 65534 ms across the wrap
    poke(32'h0000_FFEF, 1'b0, 0, 0, 0);             // 65535 ms across the wrap
    poke(32'h0001_FFEE, 1'b1, 32767, -32768, 32767);

    run_phase(INTERVAL_RESET, THR_RESET, MOVING_RESET, STILL_RESET, 250, 60, $urandom, 1'b0);
    run_phase(0, 0, 0, 0, 100, 20, $urandom, 1'b0);
    run_phase(65535, 32767, 255, 255, 560, 260, $urandom, 1'b1);
    run_phase(1, 4095, 1, 1, 100, 12, $urandom, 1'b0);
    run_phase(10, 4096, 2, 5, 100, 15, $urandom, 1'b0);
    run_phase(7, 1000, 8, 12, 150, 30, 32'hFFFF_FC00, 1'b0);
    run_phase($urandom_range(0, 20), $urandom_range(0, 32767), $urandom_range(0, 6),
              $urandom_range(0, 6), 100, 16, $urandom, 1'b0);

    settle();
    if (fail_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
